@@ sv/mute_pkg.sv @@
`timescale 1ns / 1ps
// mute_pkg: shared constants, types and edge tables for the mesh unique edge table
// no dependencies; used by the channel interfaces and the top level
package mute_pkg;

    localparam int MAX_EDGES    = 4096;
    localparam int NODE_ID_BITS = 16;
    localparam int NODE_W       = 16;
    localparam int ADDR_W       = $clog2(MAX_EDGES);
    localparam int COUNT_W      = ADDR_W + 1;
    localparam int NUM_LANES    = 12;
    localparam int LANE_W       = 4;
    localparam int KIND_W       = 2;

    localparam logic [NODE_W-1:0] NODE_MASK = NODE_W'((64'd1 << NODE_ID_BITS) - 64'd1);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [2:0] node_sel_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRI = 2'd0,
        KIND_TET = 2'd1,
        KIND_HEX = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        logic                edge_valid;
        node_t               edge_first;
        node_t               edge_second;
        logic [ADDR_W-1:0]   edge_slot;
        logic [COUNT_W-1:0]  edge_total;
        logic                table_full;
        logic                last_of_item;
        logic                mesh_done;
    } result_t;

    localparam node_sel_t TRI_A [NUM_LANES] = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam node_sel_t TRI_B [NUM_LANES] = '{1, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam node_sel_t TET_A [NUM_LANES] = '{0, 1, 0, 0, 1, 2, 0, 0, 0, 0, 0, 0};
    localparam node_sel_t TET_B [NUM_LANES] = '{1, 2, 2, 3, 3, 3, 0, 0, 0, 0, 0, 0};
    localparam node_sel_t HEX_A [NUM_LANES] = '{0, 0, 0, 1, 1, 2, 2, 3, 4, 4, 5, 6};
    localparam node_sel_t HEX_B [NUM_LANES] = '{1, 3, 4, 2, 5, 3, 6, 7, 5, 7, 6, 7};

    function automatic logic [LANE_W-1:0] pair_count(input logic [KIND_W-1:0] kind);
        logic [LANE_W-1:0] n;
        case (kind)
            KIND_TRI: n = LANE_W'(3);
            KIND_TET: n = LANE_W'(6);
            KIND_HEX: n = LANE_W'(12);
            default:  n = '0;
        endcase
        return n;
    endfunction

    function automatic node_sel_t sel_first(input logic [KIND_W-1:0] kind, input int lane);
        node_sel_t s;
        case (kind)
            KIND_TRI: s = TRI_A[lane];
            KIND_TET: s = TET_A[lane];
            KIND_HEX: s = HEX_A[lane];
            default:  s = '0;
        endcase
        return s;
    endfunction

    function automatic node_sel_t sel_second(input logic [KIND_W-1:0] kind, input int lane);
        node_sel_t s;
        case (kind)
            KIND_TRI: s = TRI_B[lane];
            KIND_TET: s = TET_B[lane];
            KIND_HEX: s = HEX_B[lane];
            default:  s = '0;
        endcase
        return s;
    endfunction

endpackage

@@ sv/mute_cfg_if.sv @@
`timescale 1ns / 1ps
// mute_cfg_if: configuration write channel carrying the element kind
// depends on mute_pkg
interface mute_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mute_pkg::KIND_W-1:0] element_kind;

    modport source (output valid, output element_kind, input ready);
    modport sink (input valid, input element_kind, output ready);
endinterface

@@ sv/mute_elem_if.sv @@
`timescale 1ns / 1ps
// mute_elem_if: input channel carrying one mesh element per transaction
// depends on mute_pkg
interface mute_elem_if;
    logic            valid;
    logic            ready;
    mute_pkg::node_t node_a;
    mute_pkg::node_t node_b;
    mute_pkg::node_t node_c;
    mute_pkg::node_t node_d;
    mute_pkg::node_t node_e;
    mute_pkg::node_t node_f;
    mute_pkg::node_t node_g;
    mute_pkg::node_t node_h;
    logic            end_of_mesh;

    modport source (output valid, output node_a, output node_b, output node_c,
                    output node_d, output node_e, output node_f, output node_g,
                    output node_h, output end_of_mesh, input ready);
    modport sink (input valid, input node_a, input node_b, input node_c,
                  input node_d, input node_e, input node_f, input node_g,
                  input node_h, input end_of_mesh, output ready);
endinterface

@@ sv/mute_edge_if.sv @@
`timescale 1ns / 1ps
// mute_edge_if: result channel carrying one edge result per transaction
// depends on mute_pkg
interface mute_edge_if;
    logic                         valid;
    logic                         ready;
    logic                         edge_valid;
    mute_pkg::node_t              edge_first;
    mute_pkg::node_t              edge_second;
    logic [mute_pkg::ADDR_W-1:0]  edge_slot;
    logic [mute_pkg::COUNT_W-1:0] edge_total;
    logic                         table_full;
    logic                         last_of_item;
    logic                         mesh_done;

    modport source (output valid, output edge_valid, output edge_first, output edge_second,
                    output edge_slot, output edge_total, output table_full,
                    output last_of_item, output mesh_done, input ready);
    modport sink (input valid, input edge_valid, input edge_first, input edge_second,
                  input edge_slot, input edge_total, input table_full,
                  input last_of_item, input mesh_done, output ready);
endinterface

@@ sv/mesh_unique_edge_table.sv @@
`timescale 1ns / 1ps
// mesh_unique_edge_table: one element per transaction; scans the edge store once
// through its single registered read port, then emits one result per new edge,
// or a single result with edge_valid low when the element adds none; the result
// channel can stall the emit step, and a new element is taken only once idle.
// reset clears the edge count, the element kind and control; the store is not cleared.
// depends on mute_pkg, mute_cfg_if, mute_elem_if, mute_edge_if
module mesh_unique_edge_table (
    input  logic        clk,
    input  logic        rst_n,
    mute_cfg_if.sink    cfg,
    mute_elem_if.sink   elem,
    mute_edge_if.source result
);
    import mute_pkg::*;

    logic [2*NODE_W-1:0] store_mem [0:MAX_EDGES-1];

    state_t                  state_reg, state_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [KIND_W-1:0]       item_kind_reg, item_kind_next;
    node_t                   node_reg [8];
    node_t                   node_next [8];
    logic                    eom_reg, eom_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [COUNT_W-1:0]      scan_reg, scan_next;
    logic [NUM_LANES-1:0]    found_reg, found_next;
    logic [LANE_W-1:0]       lane_reg, lane_next;
    logic                    pend_reg;
    logic [2*NODE_W-1:0]     rd_data_reg;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;

    logic                    rd_en;
    logic                    wr_en;
    logic [2*NODE_W-1:0]     wr_data;
    node_t                   lane_p [NUM_LANES];
    node_t                   lane_q [NUM_LANES];
    logic [NUM_LANES-1:0]    match;
    logic [NUM_LANES-1:0]    lane_mask;
    logic [NUM_LANES-1:0]    new_mask;
    logic [NUM_LANES-1:0]    above;
    logic                    out_free;
    logic                    is_full;
    node_t                   cur_p, cur_q;

    assign cfg.ready  = 1'b1;
    assign elem.ready = (state_reg == ST_IDLE);

    // edge lanes and the shared store compare
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            lane_p[k]    = node_reg[sel_first(item_kind_reg, k)];
            lane_q[k]    = node_reg[sel_second(item_kind_reg, k)];
            lane_mask[k] = (LANE_W'(k) < pair_count(item_kind_reg));
            match[k] = ((rd_data_reg[2*NODE_W-1:NODE_W] == lane_p[k]) &&
                        (rd_data_reg[NODE_W-1:0] == lane_q[k])) ||
                       ((rd_data_reg[2*NODE_W-1:NODE_W] == lane_q[k]) &&
                        (rd_data_reg[NODE_W-1:0] == lane_p[k]));
        end
    end

    assign new_mask = ~found_reg & lane_mask;
    assign above    = new_mask >> lane_reg;
    assign out_free = !out_valid_reg || result.ready;
    assign is_full  = (count_reg == COUNT_W'(MAX_EDGES));
    assign rd_en    = (state_reg == ST_SCAN) && (scan_reg != count_reg);
    assign cur_p    = lane_p[lane_reg];
    assign cur_q    = lane_q[lane_reg];
    assign wr_data  = {cur_p, cur_q};

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        item_kind_next = item_kind_reg;
        node_next      = node_reg;
        eom_next       = eom_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        lane_next      = lane_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        wr_en          = 1'b0;

        if (cfg.valid)
        begin
            kind_next = cfg.element_kind;
        end

        if (pend_reg)
        begin
            found_next = found_reg | (match & lane_mask);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (elem.valid)
                begin
                    node_next[0]   = elem.node_a & NODE_MASK;
                    node_next[1]   = elem.node_b & NODE_MASK;
                    node_next[2]   = elem.node_c & NODE_MASK;
                    node_next[3]   = elem.node_d & NODE_MASK;
                    node_next[4]   = elem.node_e & NODE_MASK;
                    node_next[5]   = elem.node_f & NODE_MASK;
                    node_next[6]   = elem.node_g & NODE_MASK;
                    node_next[7]   = elem.node_h & NODE_MASK;
                    eom_next       = elem.end_of_mesh;
                    item_kind_next = kind_reg;
                    scan_next      = '0;
                    found_next     = '0;
                    lane_next      = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    scan_next = scan_reg + COUNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (new_mask == '0)
                begin
                    // no new edge in this element
                    if (out_free)
                    begin
                        out_valid_next        = 1'b1;
                        out_next.edge_valid   = 1'b0;
                        out_next.edge_first   = '0;
                        out_next.edge_second  = '0;
                        out_next.edge_slot    = '0;
                        out_next.edge_total   = count_reg;
                        out_next.table_full   = 1'b0;
                        out_next.last_of_item = 1'b1;
                        out_next.mesh_done    = eom_reg;
                        state_next            = ST_IDLE;
                    end
                end
                else if (new_mask[lane_reg])
                begin
                    if (out_free)
                    begin
                        out_valid_next        = 1'b1;
                        out_next.edge_first   = cur_p;
                        out_next.edge_second  = cur_q;
                        out_next.last_of_item = (above[NUM_LANES-1:1] == '0);
                        out_next.mesh_done    = eom_reg && (above[NUM_LANES-1:1] == '0);
                        if (is_full)
                        begin
                            out_next.edge_valid = 1'b0;
                            out_next.edge_slot  = '0;
                            out_next.edge_total = count_reg;
                            out_next.table_full = 1'b1;
                        end
                        else
                        begin
                            wr_en               = 1'b1;
                            count_next          = count_reg + COUNT_W'(1);
                            out_next.edge_valid = 1'b1;
                            out_next.edge_slot  = count_reg[ADDR_W-1:0];
                            out_next.edge_total = count_reg + COUNT_W'(1);
                            out_next.table_full = 1'b0;
                        end
                        if (above[NUM_LANES-1:1] == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            lane_next = lane_reg + LANE_W'(1);
                        end
                    end
                end
                else
                begin
                    lane_next = lane_reg + LANE_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_TRI;
            count_reg     <= '0;
            scan_reg      <= '0;
            found_reg     <= '0;
            lane_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            found_reg     <= found_next;
            lane_reg      <= lane_next;
            pend_reg      <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_kind_reg <= item_kind_next;
        node_reg      <= node_next;
        eom_reg       <= eom_next;
        out_reg       <= out_next;
    end

    // edge store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= store_mem[scan_reg[ADDR_W-1:0]];
    end

    assign result.valid        = out_valid_reg;
    assign result.edge_valid   = out_reg.edge_valid;
    assign result.edge_first   = out_reg.edge_first;
    assign result.edge_second  = out_reg.edge_second;
    assign result.edge_slot    = out_reg.edge_slot;
    assign result.edge_total   = out_reg.edge_total;
    assign result.table_full   = out_reg.table_full;
    assign result.last_of_item = out_reg.last_of_item;
    assign result.mesh_done    = out_reg.mesh_done;

endmodule

@@ sim/mesh_unique_edge_table_tb.sv @@
`timescale 1ns / 1ps
// mesh_unique_edge_table_tb: self-checking bench for the unique edge table, with an
// in-bench edge predictor, directed element cases, random meshes and a table overflow run
// depends on mute_pkg, mute_cfg_if, mute_elem_if, mute_edge_if and mesh_unique_edge_table
module mesh_unique_edge_table_tb;
    import mute_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int IDLE_PAUSE  = 4;
    localparam int TAIL_CYCLES = 32;
    localparam int PHASE_ITEMS = 46;

    localparam int TRI_EDGES [3][2]  = '{'{0, 1}, '{1, 2}, '{0, 2}};
    localparam int TET_EDGES [6][2]  = '{'{0, 1}, '{1, 2}, '{0, 2}, '{0, 3}, '{1, 3}, '{2, 3}};
    localparam int HEX_EDGES [12][2] = '{'{0, 1}, '{0, 3}, '{0, 4}, '{1, 2}, '{1, 5}, '{2, 3},
                                         '{2, 6}, '{3, 7}, '{4, 5}, '{4, 7}, '{5, 6}, '{6, 7}};

    typedef logic [0:7][NODE_W-1:0] elem_nodes_t;

    logic clk = 1'b0;
    logic rst_n;

    mute_cfg_if  cfg_ch ();
    mute_elem_if elem_ch ();
    mute_edge_if edge_ch ();

    mesh_unique_edge_table u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .elem   (elem_ch),
        .result (edge_ch)
    );

    // predictor state
    logic [KIND_W-1:0] kind_setting = KIND_TRI;
    int                table_count = 0;
    bit                stored_edges [bit [31:0]];
    result_t           expected_edges [$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic [15:0] fresh_node = 16'hC000;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bit [31:0] edge_key(input node_t p, input node_t q);
        return (p < q) ? {p, q} : {q, p};
    endfunction

    function automatic void queue_expected(input result_t r);
        expected_edges = {expected_edges, r};
    endfunction

    function automatic void predict_edges(input elem_nodes_t nodes, input logic eom);
        int          lanes;
        int          k;
        node_t       p;
        node_t       q;
        bit [31:0]   added_keys [$];
        result_t     r;
        bit          have_r;
        case (kind_setting)
            KIND_TRI: lanes = 3;
            KIND_TET: lanes = 6;
            KIND_HEX: lanes = 12;
            default:  lanes = 0;
        endcase
        have_r = 1'b0;
        r = '0;
        for (k = 0; k < lanes; k++)
        begin
            case (kind_setting)
                KIND_TRI:
                begin
                    p = nodes[TRI_EDGES[k][0]];
                    q = nodes[TRI_EDGES[k][1]];
                end
                KIND_TET:
                begin
                    p = nodes[TET_EDGES[k][0]];
                    q = nodes[TET_EDGES[k][1]];
                end
                default:
                begin
                    p = nodes[HEX_EDGES[k][0]];
                    q = nodes[HEX_EDGES[k][1]];
                end
            endcase
            p = p & NODE_MASK;
            q = q & NODE_MASK;
            // lookups see the table as it stood before this element
            if (stored_edges.exists(edge_key(p, q)))
                continue;
            if (have_r)
                queue_expected(r);
            r = '0;
            r.edge_first = p;
            r.edge_second = q;
            if (table_count < MAX_EDGES)
            begin
                r.edge_valid = 1'b1;
                r.edge_slot = ADDR_W'(table_count);
                table_count++;
                added_keys = {added_keys, edge_key(p, q)};
            end
            else
                r.table_full = 1'b1;
            r.edge_total = COUNT_W'(table_count);
            have_r = 1'b1;
        end
        if (!have_r)
        begin
            r = '0;
            r.edge_total = COUNT_W'(table_count);
        end
        r.last_of_item = 1'b1;
        r.mesh_done = eom;
        queue_expected(r);
        foreach (added_keys[i])
            stored_edges[added_keys[i]] = 1'b1;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        result_t want;
        if (expected_edges.size() == 0)
        begin
            $error("result transaction with no expected edge pending");
            mismatch_count++;
            return;
        end
        want = expected_edges.pop_front();
        compare_field("edge_valid", 32'(want.edge_valid), 32'(edge_ch.edge_valid));
        compare_field("edge_first", 32'(want.edge_first), 32'(edge_ch.edge_first));
        compare_field("edge_second", 32'(want.edge_second), 32'(edge_ch.edge_second));
        compare_field("edge_slot", 32'(want.edge_slot), 32'(edge_ch.edge_slot));
        compare_field("edge_total", 32'(want.edge_total), 32'(edge_ch.edge_total));
        compare_field("table_full", 32'(want.table_full), 32'(edge_ch.table_full));
        compare_field("last_of_item", 32'(want.last_of_item), 32'(edge_ch.last_of_item));
        compare_field("mesh_done", 32'(want.mesh_done), 32'(edge_ch.mesh_done));
    endfunction

    // result sink with random back-pressure
    initial
    begin
        edge_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (edge_ch.valid && edge_ch.ready)
                    check_result();
                edge_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("mesh_unique_edge_table_tb: errors");
        $finish;
    end

    task automatic send_element(input elem_nodes_t nodes, input logic eom);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            elem_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        elem_ch.valid       <= 1'b1;
        elem_ch.node_a      <= nodes[0];
        elem_ch.node_b      <= nodes[1];
        elem_ch.node_c      <= nodes[2];
        elem_ch.node_d      <= nodes[3];
        elem_ch.node_e      <= nodes[4];
        elem_ch.node_f      <= nodes[5];
        elem_ch.node_g      <= nodes[6];
        elem_ch.node_h      <= nodes[7];
        elem_ch.end_of_mesh <= eom;
        do
            @(posedge clk);
        while (!elem_ch.ready);
        predict_edges(nodes, eom);
    endtask

    task automatic wait_drained();
        elem_ch.valid <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_kind(input logic [KIND_W-1:0] kind);
        wait_drained();
        repeat (IDLE_PAUSE) @(posedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.element_kind <= kind;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        kind_setting = kind;
    endtask

    function automatic logic [KIND_W-1:0] random_kind();
        if ($urandom_range(0, 9) == 0)
            return KIND_UNKNOWN;
        return KIND_W'($urandom_range(KIND_TRI, KIND_HEX));
    endfunction

    function automatic node_t pick_node(input node_t base);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (roll < 15)
            return node_t'($urandom());
        return node_t'(base + node_t'($urandom_range(0, 11)));
    endfunction

    function automatic elem_nodes_t fresh_element();
        elem_nodes_t n;
        for (int i = 0; i < 8; i++)
        begin
            n[i] = fresh_node;
            fresh_node++;
        end
        return n;
    endfunction

    // neighboring elements share nodes from a drifting window, so edges repeat
    task automatic run_random_mesh(input int send_pct, input int recv_pct);
        elem_nodes_t nodes;
        node_t       base;
        int          k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        base = node_t'($urandom());
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            if (k % 12 == 0)
                write_kind(random_kind());
            if ($urandom_range(0, 19) == 0)
                base = node_t'($urandom());
            else
                base = base + node_t'($urandom_range(0, 3));
            for (int i = 0; i < 8; i++)
                nodes[i] = pick_node(base);
            send_element(nodes, $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic test_triangle_cases();
        send_element(elem_nodes_t'{16'h0000, 16'hFFFF, 16'h5555, 16'h0000,
                                   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
        // same edges with the nodes in rotated order
        send_element(elem_nodes_t'{16'hFFFF, 16'h5555, 16'h0000, 16'h0000,
                                   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
        // repeated pair inside one element
        send_element(elem_nodes_t'{16'hAAAA, 16'hAAAA, 16'h0001, 16'h0000,
                                   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
        send_element(elem_nodes_t'{16'h0001, 16'h0002, 16'h0003, 16'hFFFF,
                                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
    endtask

    task automatic test_tet_and_hex();
        write_kind(KIND_TET);
        send_element(elem_nodes_t'{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                                   16'h1234, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
        send_element(elem_nodes_t'{default: 16'h0007}, 1'b0);
        write_kind(KIND_HEX);
        send_element(elem_nodes_t'{16'h0010, 16'h0011, 16'h0012, 16'h0013,
                                   16'h0014, 16'h0015, 16'h0016, 16'h0017}, 1'b0);
        send_element(elem_nodes_t'{16'h0010, 16'h0011, 16'h0012, 16'h0013,
                                   16'h0014, 16'h0015, 16'h0016, 16'h0017}, 1'b0);
        send_element(elem_nodes_t'{16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF,
                                   16'hFFFE, 16'h0001, 16'h5555, 16'hAAAA}, 1'b1);
    endtask

    task automatic test_unknown_kind();
        write_kind(KIND_UNKNOWN);
        send_element(elem_nodes_t'{16'h0100, 16'h0200, 16'h0300, 16'h0400,
                                   16'h0500, 16'h0600, 16'h0700, 16'h0800}, 1'b0);
        send_element(elem_nodes_t'{default: 16'hFFFF}, 1'b1);
    endtask

    task automatic test_table_overflow();
        elem_nodes_t first_fill;
        elem_nodes_t nodes;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_kind(KIND_HEX);
        first_fill = fresh_element();
        send_element(first_fill, 1'b0);
        while (MAX_EDGES - table_count > 12)
            send_element(fresh_element(), 1'b0);
        if (MAX_EDGES - table_count == 12)
        begin
            write_kind(KIND_TET);
            send_element(fresh_element(), 1'b0);
            write_kind(KIND_HEX);
        end
        // straddles the last free slots
        send_element(fresh_element(), 1'b0);
        send_element(fresh_element(), 1'b0);
        send_element(first_fill, 1'b1);
        write_kind(KIND_TRI);
        nodes = fresh_element();
        nodes[0] = first_fill[0];
        nodes[1] = first_fill[1];
        send_element(nodes, 1'b0);
        write_kind(KIND_UNKNOWN);
        send_element(fresh_element(), 1'b1);
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.element_kind <= KIND_TRI;
        elem_ch.valid       <= 1'b0;
        elem_ch.node_a      <= '0;
        elem_ch.node_b      <= '0;
        elem_ch.node_c      <= '0;
        elem_ch.node_d      <= '0;
        elem_ch.node_e      <= '0;
        elem_ch.node_f      <= '0;
        elem_ch.node_g      <= '0;
        elem_ch.node_h      <= '0;
        elem_ch.end_of_mesh <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 82;
        test_triangle_cases();
        test_tet_and_hex();
        test_unknown_kind();
        run_random_mesh(32, 82);
        run_random_mesh(82, 32);
        run_random_mesh(0, 0);
        test_table_overflow();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_edges.size() != 0)
        begin
            $error("%0d expected edge results never arrived", expected_edges.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("mesh_unique_edge_table_tb: clean");
        else
            $display("mesh_unique_edge_table_tb: errors");
        $finish;
    end

endmodule

@@ mesh_unique_edge_table.f @@
sv/mute_pkg.sv
sv/mute_cfg_if.sv
sv/mute_elem_if.sv
sv/mute_edge_if.sv
sv/mesh_unique_edge_table.sv
sim/mesh_unique_edge_table_tb.sv
